[src/grc_pkg.sv]
// Shared types and constants for the grid ray caster.
package grc_pkg;

  localparam int MAP_W     = 8;
  localparam int MAP_H     = 8;
  localparam int CELL_SIZE = 64;
  localparam int RAY_COUNT = 60;
  localparam int MAX_STEPS = 8;

  // CELL_SIZE is a power of two, so one cell in Q9.8 units is a shift.
  localparam int CELL_SHIFT = $clog2(CELL_SIZE) + 8;
  localparam int STEP_W     = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;

  localparam int DIV_N_W   = 36;
  localparam int DIV_D_W   = 18;
  localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);
  localparam int SQRT_ITER = 32;
  localparam int SQRT_CNT_W = $clog2(SQRT_ITER + 1);

  localparam logic [17:0] DIST_MAX = 18'h3FFFF;
  localparam logic [16:0] POS_MAX  = 17'h1FFFF;

  typedef enum logic [1:0] {
    CFG_WALL_MAP   = 2'd0,
    CFG_ANGLE_STEP = 2'd1,
    CFG_SCREEN_H   = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    TRIG_COS,
    TRIG_SIN,
    TRIG_FISH
  } trig_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_TRIG0,
    ST_TRIG1,
    ST_TRIG2,
    ST_TRIG3,
    ST_TRIG4,
    ST_CINIT,
    ST_CMUL,
    ST_CDIVS,
    ST_CDIVW,
    ST_CCHK,
    ST_SQA,
    ST_SQB,
    ST_SQC,
    ST_SEL,
    ST_SQRTW,
    ST_FMUL,
    ST_FRES,
    ST_HDIVS,
    ST_HDIVW,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [16:0] player_x;
    logic [16:0] player_y;
    logic [15:0] player_angle;
  } in_t;

  typedef struct packed {
    logic [5:0]  column;
    logic [17:0] wall_distance;
    logic [9:0]  line_height;
    logic [8:0]  line_top;
    logic [16:0] hit_x;
    logic [16:0] hit_y;
    logic        vertical_face;
    logic        no_hit;
    logic        last;
  } out_t;

endpackage

[src/grc_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
module grc_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [grc_pkg::DIV_N_W-1:0]   dividend_i,
  input  logic [grc_pkg::DIV_D_W-1:0]   divisor_i,
  output logic                          done_o,
  output logic [grc_pkg::DIV_N_W-1:0]   quot_o,
  output logic [grc_pkg::DIV_D_W-1:0]   rem_o
);

  logic                            busy_q, busy_d;
  logic                            done_q, done_d;
  logic [grc_pkg::DIV_CNT_W-1:0]   cnt_q, cnt_d;
  logic [grc_pkg::DIV_N_W-1:0]     quo_q, quo_d;
  logic [grc_pkg::DIV_D_W-1:0]     rem_q, rem_d;
  logic [grc_pkg::DIV_D_W-1:0]     dsr_q, dsr_d;
  logic [grc_pkg::DIV_D_W:0]       trial;
  logic [grc_pkg::DIV_D_W:0]       diff;
  logic                            ge;

  assign trial = {rem_q, quo_q[grc_pkg::DIV_N_W-1]};
  assign ge    = trial >= {1'b0, dsr_q};
  assign diff  = trial - {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = grc_pkg::DIV_CNT_W'(grc_pkg::DIV_N_W);
      quo_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[grc_pkg::DIV_D_W-1:0] : trial[grc_pkg::DIV_D_W-1:0];
      quo_d = {quo_q[grc_pkg::DIV_N_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == grc_pkg::DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

[src/grc_sqrt.sv]
// Iterative integer square root, two radicand bits per cycle.
module grc_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] value_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic                             busy_q, busy_d;
  logic                             done_q, done_d;
  logic [grc_pkg::SQRT_CNT_W-1:0]   cnt_q, cnt_d;
  logic [63:0]                      v_q, v_d;
  logic [63:0]                      r_q, r_d;
  logic [63:0]                      bit_q, bit_d;
  logic [63:0]                      sum;

  assign sum = r_q + bit_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    v_d    = v_q;
    r_d    = r_q;
    bit_d  = bit_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = grc_pkg::SQRT_CNT_W'(grc_pkg::SQRT_ITER);
      v_d    = value_i;
      r_d    = '0;
      bit_d  = 64'd1 << 62;
    end else if (busy_q) begin
      if (v_q >= sum) begin
        v_d = v_q - sum;
        r_d = (r_q >> 1) + bit_q;
      end else begin
        r_d = r_q >> 1;
      end
      bit_d = bit_q >> 2;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == grc_pkg::SQRT_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    r_q   <= r_d;
    bit_q <= bit_d;
  end

  assign done_o = done_q;
  assign root_o = r_q[31:0];

endmodule

[src/grid_ray_caster.sv]
// Top level of the grid ray caster: sequencer, shared multiplier and configuration.
//
// A frame request beat (player_x, player_y, player_angle) enters on the input
// channel when in_valid_i is high and in_stall_o is low. in_stall_o stays high
// while the frame is worked on. The block then emits RAY_COUNT column beats,
// left to right, with last set on the final one.
// Each ray runs through one registered 32x32 multiplier, a 36-bit divider
// and a 64-bit square root under a small sequencer: first the sines, then
// one multiply and one division per grid line tested, up to MAX_STEPS lines
// per axis, then the squared distances, the root, the fisheye cosine and the
// height division; root and cosine are skipped when no wall is hit, and the
// height division when the distance is zero.
// The column beat sits in an output register. While the receiver stalls, the
// sequencer waits with the next finished column until the register frees.
// Configuration writes are taken at any time and should come while idle.
// Reset empties the output register, returns to idle and loads the register
// defaults (empty map, angle_step 182, screen_height 320).
module grid_ray_caster (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  grc_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output grc_pkg::out_t  out_data_o,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [63:0]    cfg_wdata_i
);

  localparam int CS = grc_pkg::CELL_SHIFT;

  function automatic logic [30:0] mag_clamp(input logic signed [38:0] e);
    logic [38:0] m;
    m = e[38] ? 39'(-e) : 39'(e);
    if (m > 39'(1 << 30)) begin
      m = 39'(1 << 30);
    end
    return m[30:0];
  endfunction

  function automatic logic [16:0] clamp_pos(input logic signed [37:0] v);
    logic [16:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed({21'd0, grc_pkg::POS_MAX})) begin
      r = grc_pkg::POS_MAX;
    end else begin
      r = v[16:0];
    end
    return r;
  endfunction

  logic [63:0] wall_map_q;
  logic [11:0] angle_step_q;
  logic [9:0]  screen_h_q;

  grc_pkg::state_e state_q, state_d;
  grc_pkg::trig_e  trig_q, trig_d;

  logic [16:0] px_q, px_d, py_q, py_d;
  logic [15:0] pa_q, pa_d, ray_q, ray_d;
  logic [5:0]  col_q, col_d;
  logic [63:0] p_q, prod;
  logic [31:0] mul_a, mul_b;
  logic [14:0] z_q, z_d, z2_q, z2_d;
  logic        sgn_q, sgn_d;
  logic signed [15:0] cos_q, cos_d, sin_q, sin_d, fc_q, fc_d;
  logic        axis_q, axis_d;
  logic signed [5:0] b_q, b_d;
  logic [grc_pkg::STEP_W-1:0] k_q, k_d;
  logic        neg_q, neg_d;
  logic signed [37:0] hx_q [2];
  logic signed [37:0] hx_d [2];
  logic signed [37:0] hy_q [2];
  logic signed [37:0] hy_d [2];
  logic [1:0]  hit_q, hit_d;
  logic [61:0] sq_q [2];
  logic [61:0] sq_d [2];
  logic [60:0] acc_q, acc_d;
  logic        vert_q, vert_d, none_q, none_d;
  logic [16:0] ox_q, ox_d, oy_q, oy_d;
  logic [31:0] raw_q, raw_d;
  logic [17:0] dist_q, dist_d;
  logic [9:0]  h_q, h_d;
  grc_pkg::out_t out_q, out_d;
  logic        out_valid_q, out_valid_d;

  logic                          div_start, div_done;
  logic [grc_pkg::DIV_N_W-1:0]   div_dividend, div_quot;
  logic [grc_pkg::DIV_D_W-1:0]   div_divisor, div_rem;
  logic                          sqrt_start, sqrt_done;
  logic [63:0]                   sqrt_value;
  logic [31:0]                   sqrt_root;

  logic [15:0]  trig_ang;
  logic [13:0]  tt;
  logic [14:0]  tz, f;
  logic [16:0]  pp, ps;
  logic signed [15:0] dp, ds;
  logic [14:0]  dp_mag, ds_mag;
  logic signed [20:0] lp, diff;
  logic [19:0]  diff_mag;
  logic signed [37:0] qs, ls;
  logic signed [23:0] cs, cp, row, col;
  logic         solid;
  logic [6:0]   bit_idx;
  logic [30:0]  ex_mag, ey_mag;
  logic         ch0;
  logic [17:0]  half;
  logic [44:0]  fprod;

  grc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  grc_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .value_i (sqrt_value),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  assign prod = mul_a * mul_b;

  always_comb begin
    unique case (trig_q)
      grc_pkg::TRIG_COS:  trig_ang = ray_q + 16'd16384;
      grc_pkg::TRIG_SIN:  trig_ang = ray_q;
      grc_pkg::TRIG_FISH: trig_ang = pa_q - ray_q + 16'd16384;
      default:            trig_ang = ray_q;
    endcase
  end

  assign tt = trig_ang[13:0];
  assign tz = trig_ang[14] ? 15'(15'd16384 - {1'b0, tt}) : {1'b0, tt};
  assign f  = 15'(p_q >> 15);

  assign pp     = axis_q ? px_q : py_q;
  assign ps     = axis_q ? py_q : px_q;
  assign dp     = axis_q ? cos_q : sin_q;
  assign ds     = axis_q ? sin_q : cos_q;
  assign dp_mag = dp[15] ? 15'(-dp) : 15'(dp);
  assign ds_mag = ds[15] ? 15'(-ds) : 15'(ds);
  assign lp       = 21'(b_q) <<< CS;
  assign diff     = lp - $signed({4'd0, pp});
  assign diff_mag = diff[20] ? 20'(-diff) : 20'(diff);

  assign qs = neg_q ? -($signed({2'b00, div_quot}) + 38'(div_rem != '0))
                    : $signed({2'b00, div_quot});
  assign ls = $signed({21'd0, ps}) + qs;
  assign cs = 24'(ls >>> CS);
  assign cp = dp[15] ? 24'(b_q) - 24'sd1 : 24'(b_q);
  assign row = axis_q ? cs : cp;
  assign col = axis_q ? cp : cs;
  assign bit_idx = 7'(row[3:0] * grc_pkg::MAP_W + col[3:0]);
  assign solid = (row >= 0) && (row < 24'(grc_pkg::MAP_H)) &&
                 (col >= 0) && (col < 24'(grc_pkg::MAP_W)) &&
                 wall_map_q[bit_idx[5:0]];

  assign ex_mag = mag_clamp(39'(hx_q[axis_q]) - $signed({22'd0, px_q}));
  assign ey_mag = mag_clamp(39'(hy_q[axis_q]) - $signed({22'd0, py_q}));
  assign ch0    = hit_q[0] && (!hit_q[1] || (sq_q[0] <= sq_q[1]));
  assign half   = 18'(grc_pkg::RAY_COUNT * angle_step_q) >> 1;
  assign fprod  = p_q[44:0];

  always_comb begin
    state_d = state_q;
    trig_d  = trig_q;
    px_d = px_q;
    py_d = py_q;
    pa_d = pa_q;
    ray_d = ray_q;
    col_d = col_q;
    z_d = z_q;
    z2_d = z2_q;
    sgn_d = sgn_q;
    cos_d = cos_q;
    sin_d = sin_q;
    fc_d = fc_q;
    axis_d = axis_q;
    b_d = b_q;
    k_d = k_q;
    neg_d = neg_q;
    hx_d = hx_q;
    hy_d = hy_q;
    hit_d = hit_q;
    sq_d = sq_q;
    acc_d = acc_q;
    vert_d = vert_q;
    none_d = none_q;
    ox_d = ox_q;
    oy_d = oy_q;
    raw_d = raw_q;
    dist_d = dist_q;
    h_d = h_q;
    out_d = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    mul_a = '0;
    mul_b = '0;
    div_start = 1'b0;
    div_dividend = 36'(p_q);
    div_divisor = 18'(dp_mag);
    sqrt_start = 1'b0;
    sqrt_value = {2'b00, sq_q[0]};

    unique case (state_q)
      grc_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          px_d = in_data_i.player_x;
          py_d = in_data_i.player_y;
          pa_d = in_data_i.player_angle;
          ray_d = in_data_i.player_angle - half[15:0];
          col_d = '0;
          trig_d = grc_pkg::TRIG_COS;
          state_d = grc_pkg::ST_TRIG0;
        end
      end
      grc_pkg::ST_TRIG0: begin
        z_d = tz;
        sgn_d = trig_ang[15];
        mul_a = 32'(tz);
        mul_b = 32'(tz);
        state_d = grc_pkg::ST_TRIG1;
      end
      grc_pkg::ST_TRIG1: begin
        z2_d = 15'(p_q >> 14);
        mul_a = 32'(15'(p_q >> 14));
        mul_b = 32'd2320;
        state_d = grc_pkg::ST_TRIG2;
      end
      grc_pkg::ST_TRIG2: begin
        mul_a = 32'(z2_q);
        mul_b = 32'(15'd21024 - 15'(p_q >> 14));
        state_d = grc_pkg::ST_TRIG3;
      end
      grc_pkg::ST_TRIG3: begin
        mul_a = 32'(z_q);
        mul_b = 32'd51472 - 32'(15'(p_q >> 14));
        state_d = grc_pkg::ST_TRIG4;
      end
      grc_pkg::ST_TRIG4: begin
        unique case (trig_q)
          grc_pkg::TRIG_COS: begin
            cos_d = sgn_q ? -$signed({1'b0, f}) : $signed({1'b0, f});
            trig_d = grc_pkg::TRIG_SIN;
            state_d = grc_pkg::ST_TRIG0;
          end
          grc_pkg::TRIG_SIN: begin
            sin_d = sgn_q ? -$signed({1'b0, f}) : $signed({1'b0, f});
            axis_d = 1'b0;
            state_d = grc_pkg::ST_CINIT;
          end
          default: begin
            fc_d = sgn_q ? -$signed({1'b0, f}) : $signed({1'b0, f});
            state_d = grc_pkg::ST_FMUL;
          end
        endcase
      end
      grc_pkg::ST_CINIT: begin
        hit_d[axis_q] = 1'b0;
        b_d = $signed(6'(pp >> CS) + 6'(dp > 0));
        k_d = '0;
        if (dp == 0) begin
          if (axis_q) begin
            axis_d = 1'b0;
            state_d = grc_pkg::ST_SQA;
          end else begin
            axis_d = 1'b1;
          end
        end else begin
          state_d = grc_pkg::ST_CMUL;
        end
      end
      grc_pkg::ST_CMUL: begin
        mul_a = 32'(diff_mag);
        mul_b = 32'(ds_mag);
        neg_d = diff[20] ^ ds[15] ^ dp[15];
        state_d = grc_pkg::ST_CDIVS;
      end
      grc_pkg::ST_CDIVS: begin
        div_start = 1'b1;
        state_d = grc_pkg::ST_CDIVW;
      end
      grc_pkg::ST_CDIVW: begin
        if (div_done) begin
          state_d = grc_pkg::ST_CCHK;
        end
      end
      grc_pkg::ST_CCHK: begin
        if (solid || k_q == grc_pkg::STEP_W'(grc_pkg::MAX_STEPS - 1)) begin
          if (solid) begin
            hit_d[axis_q] = 1'b1;
            hx_d[axis_q] = axis_q ? 38'(lp) : ls;
            hy_d[axis_q] = axis_q ? ls : 38'(lp);
          end
          if (axis_q) begin
            axis_d = 1'b0;
            state_d = grc_pkg::ST_SQA;
          end else begin
            axis_d = 1'b1;
            state_d = grc_pkg::ST_CINIT;
          end
        end else begin
          b_d = dp[15] ? b_q - 6'sd1 : b_q + 6'sd1;
          k_d = k_q + 1'b1;
          state_d = grc_pkg::ST_CMUL;
        end
      end
      grc_pkg::ST_SQA: begin
        mul_a = 32'(ex_mag);
        mul_b = 32'(ex_mag);
        state_d = grc_pkg::ST_SQB;
      end
      grc_pkg::ST_SQB: begin
        acc_d = p_q[60:0];
        mul_a = 32'(ey_mag);
        mul_b = 32'(ey_mag);
        state_d = grc_pkg::ST_SQC;
      end
      grc_pkg::ST_SQC: begin
        sq_d[axis_q] = 62'(acc_q) + 62'(p_q[60:0]);
        if (axis_q) begin
          state_d = grc_pkg::ST_SEL;
        end else begin
          axis_d = 1'b1;
          state_d = grc_pkg::ST_SQA;
        end
      end
      grc_pkg::ST_SEL: begin
        if (ch0) begin
          ox_d = clamp_pos(hx_q[0]);
          oy_d = clamp_pos(hy_q[0]);
          vert_d = 1'b0;
          none_d = 1'b0;
          sqrt_start = 1'b1;
          sqrt_value = {2'b00, sq_q[0]};
          state_d = grc_pkg::ST_SQRTW;
        end else if (hit_q[1]) begin
          ox_d = clamp_pos(hx_q[1]);
          oy_d = clamp_pos(hy_q[1]);
          vert_d = 1'b1;
          none_d = 1'b0;
          sqrt_start = 1'b1;
          sqrt_value = {2'b00, sq_q[1]};
          state_d = grc_pkg::ST_SQRTW;
        end else begin
          ox_d = px_q;
          oy_d = py_q;
          vert_d = 1'b0;
          none_d = 1'b1;
          dist_d = grc_pkg::DIST_MAX;
          state_d = grc_pkg::ST_HDIVS;
        end
      end
      grc_pkg::ST_SQRTW: begin
        if (sqrt_done) begin
          raw_d = sqrt_root;
          trig_d = grc_pkg::TRIG_FISH;
          state_d = grc_pkg::ST_TRIG0;
        end
      end
      grc_pkg::ST_FMUL: begin
        if (fc_q <= 0) begin
          dist_d = '0;
          state_d = grc_pkg::ST_HDIVS;
        end else begin
          mul_a = raw_q;
          mul_b = 32'(fc_q[14:0]);
          state_d = grc_pkg::ST_FRES;
        end
      end
      grc_pkg::ST_FRES: begin
        dist_d = ((fprod >> 14) > 45'(grc_pkg::DIST_MAX)) ? grc_pkg::DIST_MAX
                                                          : 18'(fprod >> 14);
        state_d = grc_pkg::ST_HDIVS;
      end
      grc_pkg::ST_HDIVS: begin
        if (dist_q == '0) begin
          h_d = screen_h_q;
          state_d = grc_pkg::ST_EMIT;
        end else begin
          div_start = 1'b1;
          div_dividend = 36'(screen_h_q) << CS;
          div_divisor = dist_q;
          state_d = grc_pkg::ST_HDIVW;
        end
      end
      grc_pkg::ST_HDIVW: begin
        if (div_done) begin
          h_d = (div_quot > 36'(screen_h_q)) ? screen_h_q : div_quot[9:0];
          state_d = grc_pkg::ST_EMIT;
        end
      end
      grc_pkg::ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_d.column = col_q;
          out_d.wall_distance = dist_q;
          out_d.line_height = h_q;
          out_d.line_top = 9'((screen_h_q >> 1) - (h_q >> 1));
          out_d.hit_x = ox_q;
          out_d.hit_y = oy_q;
          out_d.vertical_face = vert_q;
          out_d.no_hit = none_q;
          out_d.last = (col_q == 6'(grc_pkg::RAY_COUNT - 1));
          if (col_q == 6'(grc_pkg::RAY_COUNT - 1)) begin
            state_d = grc_pkg::ST_IDLE;
          end else begin
            ray_d = ray_q + 16'(angle_step_q);
            col_d = col_q + 1'b1;
            trig_d = grc_pkg::TRIG_COS;
            state_d = grc_pkg::ST_TRIG0;
          end
        end
      end
      default: state_d = grc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= grc_pkg::ST_IDLE;
      trig_q       <= grc_pkg::TRIG_COS;
      out_valid_q  <= 1'b0;
      wall_map_q   <= '0;
      angle_step_q <= 12'd182;
      screen_h_q   <= 10'd320;
      ray_q        <= '0;
      col_q        <= '0;
      px_q         <= '0;
      py_q         <= '0;
      axis_q       <= 1'b0;
      k_q          <= '0;
      hit_q        <= '0;
    end else begin
      state_q     <= state_d;
      trig_q      <= trig_d;
      out_valid_q <= out_valid_d;
      ray_q       <= ray_d;
      col_q       <= col_d;
      px_q        <= px_d;
      py_q        <= py_d;
      axis_q      <= axis_d;
      k_q         <= k_d;
      hit_q       <= hit_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          grc_pkg::CFG_WALL_MAP:   wall_map_q   <= cfg_wdata_i;
          grc_pkg::CFG_ANGLE_STEP: angle_step_q <= cfg_wdata_i[11:0];
          grc_pkg::CFG_SCREEN_H:   screen_h_q   <= cfg_wdata_i[9:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pa_q   <= pa_d;
    p_q    <= prod;
    z_q    <= z_d;
    z2_q   <= z2_d;
    sgn_q  <= sgn_d;
    cos_q  <= cos_d;
    sin_q  <= sin_d;
    fc_q   <= fc_d;
    b_q    <= b_d;
    neg_q  <= neg_d;
    hx_q   <= hx_d;
    hy_q   <= hy_d;
    sq_q   <= sq_d;
    acc_q  <= acc_d;
    vert_q <= vert_d;
    none_q <= none_d;
    ox_q   <= ox_d;
    oy_q   <= oy_d;
    raw_q  <= raw_d;
    dist_q <= dist_d;
    h_q    <= h_d;
    out_q  <= out_d;
  end

  assign in_stall_o  = (state_q != grc_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
